>>> src/hsl_pkg.sv
package hsl_pkg;

    // Divider geometry: dividend, divisor, quotient widths
    localparam int DIVW  = 27;
    localparam int DSRW  = 11;
    localparam int QW    = 18;
    localparam int CW    = DSRW + QW;
    localparam int LANES = 2;

    // Divider lanes
    localparam int LN_SAT = 0;  // saturation
    localparam int LN_HUE = 1;  // hue

    // Register indexes
    localparam logic [1:0] REG_HUE_ROTATE = 2'd0;
    localparam logic [1:0] REG_SAT_SCALE  = 2'd1;
    localparam logic [1:0] REG_LUM_SCALE  = 2'd2;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    typedef struct packed {
        logic [DIVW-1:0] num;
        logic [DSRW-1:0] den;
    } div_req_t;

    // Data that rides along the divider
    typedef struct packed {
        pix_t        pix;
        logic        ofs_neg;
        logic [16:0] lum;   // lightness, Q16
        logic [17:0] ofs;   // lightness offset magnitude, Q16
    } side_t;

endpackage

>>> src/hsl_adjust_pixel.sv
// HSL adjust of an RGBA8 pixel stream. Each pixel is taken to hue,
// saturation and lightness, the hue is rotated by hue_rotate/65536 of a turn,
// saturation is scaled by sat_scale/16384, lightness gets
// (lum_scale/16384 - 1) * alpha/255 added, and the pixel goes back to RGB,
// each channel clamped to [0,1] and floored to 8 bits. Pixels with alpha
// zero leave unchanged; alpha is always kept. One pixel per clock as long as
// the output is not held back by m_axis_tready; the bulk of the pipeline is
// the 18-stage bit-per-stage divider that yields saturation and hue.
// Lightness and its offset are divisions by 255, done as reciprocal
// multiplications in front of the divider and carried along with it. The
// whole pipeline freezes while a finished result waits on m_axis_tready, so
// nothing is lost. Write the config registers only with the pipeline drained.
module hsl_adjust_pixel
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input pixels
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    // output pixels
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // out_red, out_green, out_blue, out_alpha
);

    // ---------------- config registers ----------------
    logic [15:0] hue_rotate_reg;
    logic [15:0] sat_scale_reg;
    logic [15:0] lum_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_rotate_reg <= 16'd0;
            sat_scale_reg  <= 16'd16384;
            lum_scale_reg  <= 16'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hsl_pkg::REG_HUE_ROTATE: hue_rotate_reg <= cfg_data;
                hsl_pkg::REG_SAT_SCALE:  sat_scale_reg  <= cfg_data;
                hsl_pkg::REG_LUM_SCALE:  lum_scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    // Single global enable: everything moves unless the output holds a
    // result that is not being taken.
    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 0: input register ----------------
    logic          s0_vld_reg;
    hsl_pkg::pix_t s0_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_pix_reg <= s_axis_tdata;
        end
    end

    // ---------------- stage 1: divider operands ----------------
    logic [7:0]         mx, mn, dd;
    logic [8:0]         sum;
    logic [8:0]         sden;
    logic [10:0]        d6;
    logic signed [11:0] hn;
    logic signed [16:0] lm;
    logic signed [26:0] lx;
    logic               ofs_neg;
    logic [26:0]        ofs_mag;
    hsl_pkg::div_req_t [hsl_pkg::LANES-1:0] req_next;

    always_comb
    begin
        mx = (s0_pix_reg.red > s0_pix_reg.green) ? s0_pix_reg.red : s0_pix_reg.green;
        if (s0_pix_reg.blue > mx)
        begin
            mx = s0_pix_reg.blue;
        end
        mn = (s0_pix_reg.red < s0_pix_reg.green) ? s0_pix_reg.red : s0_pix_reg.green;
        if (s0_pix_reg.blue < mn)
        begin
            mn = s0_pix_reg.blue;
        end
        dd   = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};
        sden = (sum < 9'd255) ? sum : 9'd510 - sum;
        d6   = {1'b0, dd, 2'b00} + {2'b00, dd, 1'b0};

        // hue numerator over six times the chroma
        if (s0_pix_reg.red == mx)
        begin
            hn = $signed({4'b0, s0_pix_reg.green}) - $signed({4'b0, s0_pix_reg.blue});
        end
        else if (s0_pix_reg.green == mx)
        begin
            hn = $signed({3'b0, dd, 1'b0}) + $signed({4'b0, s0_pix_reg.blue})
               - $signed({4'b0, s0_pix_reg.red});
        end
        else
        begin
            hn = $signed({2'b0, dd, 2'b0}) + $signed({4'b0, s0_pix_reg.red})
               - $signed({4'b0, s0_pix_reg.green});
        end
        if (hn < 12'sd0)
        begin
            hn = hn + $signed({1'b0, d6});
        end

        // lightness offset (lum-1)*alpha*4, floor-divided by 255 as a magnitude
        lm      = $signed({1'b0, lum_scale_reg}) - 17'sd16384;
        lx      = (27'(lm) * 27'($signed({1'b0, s0_pix_reg.alpha}))) <<< 2;
        ofs_neg = lx[26];
        ofs_mag = ofs_neg ? 27'(-lx) + 27'd254 : lx;

        if (dd == 8'd0)
        begin
            req_next[hsl_pkg::LN_SAT].num = '0;
            req_next[hsl_pkg::LN_SAT].den = 11'd1;
            req_next[hsl_pkg::LN_HUE].num = '0;
            req_next[hsl_pkg::LN_HUE].den = 11'd1;
        end
        else
        begin
            req_next[hsl_pkg::LN_SAT].num = {3'b0, dd, 16'b0};
            req_next[hsl_pkg::LN_SAT].den = {2'b0, sden};
            req_next[hsl_pkg::LN_HUE].num = {hn[10:0], 16'b0};
            req_next[hsl_pkg::LN_HUE].den = d6;
        end
    end

    logic                                   s1_vld_reg;
    hsl_pkg::div_req_t [hsl_pkg::LANES-1:0] s1_req_reg;
    hsl_pkg::pix_t                          s1_pix_reg;
    logic                                   s1_ofs_neg_reg;
    logic [26:0]                            s1_ofs_mag_reg;
    logic [8:0]                             s1_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_req_reg     <= req_next;
            s1_pix_reg     <= s0_pix_reg;
            s1_ofs_neg_reg <= ofs_neg;
            s1_ofs_mag_reg <= ofs_mag;
            s1_sum_reg     <= sum;
        end
    end

    // ---------------- divisions by 255 ----------------
    // floor(x/255) as (x * ceil(2^39/255)) >> 39, exact for any 27-bit x
    function automatic logic [19:0] div255(input logic [26:0] x);
        logic [58:0] p;
        begin
            p      = 59'(x) * 59'(32'h80808081);
            div255 = p[58:39];
        end
    endfunction

    logic [19:0]    lum_div;
    logic [19:0]    ofs_div;
    hsl_pkg::side_t div_side;

    always_comb
    begin
        // (max+min)*65536/510 = (max+min)*32768/255
        lum_div          = div255({3'b0, s1_sum_reg, 15'b0});
        ofs_div          = div255(s1_ofs_mag_reg);
        div_side.pix     = s1_pix_reg;
        div_side.ofs_neg = s1_ofs_neg_reg;
        div_side.lum     = lum_div[16:0];
        div_side.ofs     = ofs_div[17:0];
    end

    // ---------------- divider ----------------
    logic                                            dv_vld;
    logic [hsl_pkg::LANES-1:0][hsl_pkg::QW-1:0]      dv_quo;
    hsl_pkg::side_t                                  dv_side;

    hsl_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_vld_reg),
        .req       (s1_req_reg),
        .in_side   (div_side),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .out_side  (dv_side)
    );

    // ---------------- P1: rotate, scale, offset ----------------
    logic signed [19:0] ofs;
    logic signed [19:0] l2_next;

    always_comb
    begin
        ofs = dv_side.ofs_neg ? -$signed({2'b0, dv_side.ofs})
                              :  $signed({2'b0, dv_side.ofs});
        l2_next = $signed({3'b0, dv_side.lum}) + ofs;
    end

    logic               p1_vld_reg;
    hsl_pkg::pix_t      p1_pix_reg;
    logic [15:0]        p1_h2_reg;
    logic [32:0]        p1_s2p_reg;
    logic signed [19:0] p1_l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_pix_reg <= dv_side.pix;
            p1_h2_reg  <= dv_quo[hsl_pkg::LN_HUE][15:0] + hue_rotate_reg;
            p1_s2p_reg <= 33'(dv_quo[hsl_pkg::LN_SAT][16:0]) * 33'(sat_scale_reg);
            p1_l2_reg  <= l2_next;
        end
    end

    // ---------------- P2: L*S product, channel hues ----------------
    logic [18:0] s2;

    assign s2 = p1_s2p_reg[32:14];

    logic               p2_vld_reg;
    hsl_pkg::pix_t      p2_pix_reg;
    logic [2:0][15:0]   p2_hue_reg;     // red, green, blue
    logic [18:0]        p2_s2_reg;
    logic signed [19:0] p2_l2_reg;
    logic signed [39:0] p2_ls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_pix_reg    <= p1_pix_reg;
            p2_hue_reg[0] <= p1_h2_reg + 16'd21845;
            p2_hue_reg[1] <= p1_h2_reg;
            p2_hue_reg[2] <= p1_h2_reg - 16'd21845;
            p2_s2_reg     <= s2;
            p2_l2_reg     <= p1_l2_reg;
            p2_ls_reg     <= 40'(p1_l2_reg) * 40'($signed({1'b0, s2}));
        end
    end

    // ---------------- P3: f1, f2 and segment weights ----------------
    // Segment weight w (Q16): result = f1 + (f2-f1)*w/65536. Rising edge,
    // flat top (w = 1.0), falling edge, floor (w = 0).
    function automatic logic [16:0] seg_weight(input logic [15:0] h);
        logic [18:0] h6;
        logic [17:0] h3;
        logic [16:0] t;
        logic [19:0] t6;
        begin
            h6 = {1'b0, h, 2'b0} + {2'b0, h, 1'b0};
            h3 = {1'b0, h, 1'b0} + {2'b0, h};
            t  = 17'd43691 - {1'b0, h};
            t6 = {1'b0, t, 2'b0} + {2'b0, t, 1'b0};
            if (h6 < 19'd65536)
            begin
                seg_weight = h6[16:0];
            end
            else if (h < 16'd32768)
            begin
                seg_weight = 17'd65536;
            end
            else if (h3 < 18'd131072)
            begin
                seg_weight = t6[16:0];
            end
            else
            begin
                seg_weight = 17'd0;
            end
        end
    endfunction

    logic signed [23:0] prod;
    logic signed [25:0] l2x;
    logic signed [25:0] f2;
    logic signed [25:0] f1;

    always_comb
    begin
        prod = p2_ls_reg[39:16];
        l2x  = {{6{p2_l2_reg[19]}}, p2_l2_reg};
        if (p2_l2_reg < 20'sd32768)
        begin
            f2 = l2x + {{2{prod[23]}}, prod};
        end
        else
        begin
            f2 = l2x + $signed({7'b0, p2_s2_reg}) - {{2{prod[23]}}, prod};
        end
        f1 = (l2x <<< 1) - f2;
    end

    logic               p3_vld_reg;
    hsl_pkg::pix_t      p3_pix_reg;
    logic signed [25:0] p3_f1_reg;
    logic signed [25:0] p3_df_reg;
    logic [2:0][16:0]   p3_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_pix_reg <= p2_pix_reg;
            p3_f1_reg  <= f1;
            p3_df_reg  <= f2 - f1;
            for (int c = 0; c < 3; c++)
            begin
                p3_w_reg[c] <= seg_weight(p2_hue_reg[c]);
            end
        end
    end

    // ---------------- P4: channel products ----------------
    logic               p4_vld_reg;
    hsl_pkg::pix_t      p4_pix_reg;
    logic signed [25:0] p4_f1_reg;
    logic signed [43:0] p4_mp_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p4_vld_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_pix_reg <= p3_pix_reg;
            p4_f1_reg  <= p3_f1_reg;
            for (int c = 0; c < 3; c++)
            begin
                p4_mp_reg[c] <= 44'(p3_df_reg) * 44'($signed({1'b0, p3_w_reg[c]}));
            end
        end
    end

    // ---------------- P5: clamp, scale to bytes, output register ----------------
    logic signed [27:0] chv [3];
    logic [16:0]        chc [3];
    logic [24:0]        chs [3];
    logic [2:0][7:0]    chb;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            chv[c] = {{2{p4_f1_reg[25]}}, p4_f1_reg} + p4_mp_reg[c][43:16];
            if (chv[c] < 28'sd0)
            begin
                chc[c] = 17'd0;
            end
            else if (chv[c] > 28'sd65536)
            begin
                chc[c] = 17'd65536;
            end
            else
            begin
                chc[c] = chv[c][16:0];
            end
            chs[c] = {chc[c], 8'b0} - {8'b0, chc[c]};
            chb[c] = chs[c][23:16];
        end
    end

    hsl_pkg::pix_t out_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pix_reg.alpha <= p4_pix_reg.alpha;
            if (p4_pix_reg.alpha == 8'd0)
            begin
                // fully transparent: pass through
                out_pix_reg.red   <= p4_pix_reg.red;
                out_pix_reg.green <= p4_pix_reg.green;
                out_pix_reg.blue  <= p4_pix_reg.blue;
            end
            else
            begin
                out_pix_reg.red   <= chb[0];
                out_pix_reg.green <= chb[1];
                out_pix_reg.blue  <= chb[2];
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_pix_reg;

endmodule

>>> src/hsl_div.sv
module hsl_div
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           en,
    input  logic                                           in_valid,
    input  hsl_pkg::div_req_t [hsl_pkg::LANES-1:0]         req,
    input  hsl_pkg::side_t                                 in_side,
    output logic                                           out_valid,
    output logic [hsl_pkg::LANES-1:0][hsl_pkg::QW-1:0]     quo,
    output hsl_pkg::side_t                                 out_side
);

    // One quotient bit per stage, MSB first, restoring division on all lanes.
    logic [hsl_pkg::QW-1:0]                                    vld_reg;
    hsl_pkg::side_t                                            side_reg [hsl_pkg::QW];
    logic [hsl_pkg::LANES-1:0][hsl_pkg::DIVW-1:0]              rem_reg  [hsl_pkg::QW];
    logic [hsl_pkg::LANES-1:0][hsl_pkg::DSRW-1:0]              den_reg  [hsl_pkg::QW];
    logic [hsl_pkg::LANES-1:0][hsl_pkg::QW-1:0]                q_reg    [hsl_pkg::QW];

    for (genvar k = 0; k < hsl_pkg::QW; k++) begin : g_st
        localparam int SH = hsl_pkg::QW - 1 - k;

        logic                                              vld_in;
        hsl_pkg::side_t                                    side_in;
        logic [hsl_pkg::LANES-1:0][hsl_pkg::DIVW-1:0]      rem_in;
        logic [hsl_pkg::LANES-1:0][hsl_pkg::DIVW-1:0]      rem_next;
        logic [hsl_pkg::LANES-1:0][hsl_pkg::DSRW-1:0]      den_in;
        logic [hsl_pkg::LANES-1:0][hsl_pkg::QW-1:0]        q_in;
        logic [hsl_pkg::LANES-1:0][hsl_pkg::QW-1:0]        q_next;
        logic [hsl_pkg::LANES-1:0][hsl_pkg::CW-1:0]        trial;
        logic [hsl_pkg::LANES-1:0]                         ge;

        if (k == 0) begin : g_first
            always_comb
            begin
                vld_in  = in_valid;
                side_in = in_side;
                for (int l = 0; l < hsl_pkg::LANES; l++)
                begin
                    rem_in[l] = req[l].num;
                    den_in[l] = req[l].den;
                    q_in[l]   = '0;
                end
            end
        end else begin : g_next
            always_comb
            begin
                vld_in  = vld_reg[k-1];
                side_in = side_reg[k-1];
                rem_in  = rem_reg[k-1];
                den_in  = den_reg[k-1];
                q_in    = q_reg[k-1];
            end
        end

        always_comb
        begin
            for (int l = 0; l < hsl_pkg::LANES; l++)
            begin
                trial[l]    = hsl_pkg::CW'(den_in[l]) << SH;
                ge[l]       = hsl_pkg::CW'(rem_in[l]) >= trial[l];
                rem_next[l] = ge[l] ? rem_in[l] - trial[l][hsl_pkg::DIVW-1:0] : rem_in[l];
                q_next[l]   = q_in[l] | (hsl_pkg::QW'(ge[l]) << SH);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                q_reg[k]    <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[hsl_pkg::QW-1];
    assign quo       = q_reg[hsl_pkg::QW-1];
    assign out_side  = side_reg[hsl_pkg::QW-1];

endmodule
